FILE: design/assert_macros.svh
// Assertion helpers shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: design/sfl_pkg.sv
`default_nettype none

package sfl_pkg;

  // Field widths of the request and response.
  localparam int CMD_W = 2;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int ID_W  = 32;

  // Default pool size and reset values.
  localparam int POOL_DEPTH_DEF = 1024;
  localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] USED_MAX = 11'd2047;
  localparam logic [ID_W-1:0]  ID_RESET = 32'd1;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_NEXT_ID = 2'd2,
    CMD_INIT    = 2'd3
  } cmd_t;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: design/sfl_ram.sv
`default_nettype none
`include "assert_macros.svh"

module sfl_ram
  import sfl_pkg::*;
#(
  parameter int WIDTH = CNT_W,
  parameter int DEPTH = POOL_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/indexed_slot_free_list_allocator.sv
// Throughput: one request per cycle for every command, allocate chains included, while no
// clearing pass runs and no response waits, because the link of the new head comes straight
// from the link memory's registered read port. Reset and the init command rebuild the free
// list with a clearing pass over the slots of the rebuilt pool (at most POOL_DEPTH); requests
// wait in the input register meanwhile, and each response is held in the response register.
// Reset is synchronous and active high; the slot count register resets to 1024.
`default_nettype none
`include "assert_macros.svh"

module indexed_slot_free_list_allocator
  import sfl_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] slot_count,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [CMD_W-1:0] command,
  input  logic [IDX_W-1:0] slot_index,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic [1:0]       status,
  output logic [IDX_W-1:0] granted_index,
  output logic [CNT_W-1:0] slots_in_use,
  output logic [ID_W-1:0]  ticket_id
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int SW = (CW > CNT_W) ? CW : CNT_W;
  localparam int FW = (CW > IDX_W) ? CW : IDX_W;

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] link;
  } link_t;

  // Configuration and input register.
  logic [CNT_W-1:0] slot_count_q;
  logic             req_full_q;
  cmd_t             cmd_q;
  logic [IDX_W-1:0] idx_q;

  // Free list state.
  logic [CW-1:0]    live_count_q, live_count_next;
  logic [AW-1:0]    head_q, head_next;
  logic             head_valid_q, head_valid_next;
  link_t            head_link_q, head_link_next;
  logic             link_fresh_q, link_fresh_next;
  logic [CNT_W-1:0] used_q, used_next;
  logic [ID_W-1:0]  id_q, id_next;
  logic             sweeping_q;
  logic [AW-1:0]    sweep_idx_q;

  // Response register.
  logic             rsp_valid_q;
  status_t          status_q, status_next;
  logic [IDX_W-1:0] granted_q, granted_next;
  logic [CNT_W-1:0] rsp_used_q;
  logic [ID_W-1:0]  ticket_id_q, ticket_id_next;

  // Link memory ports.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  link_t            ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [AW:0]      ram_rdata;

  logic             proc_go;
  logic             start_sweep;
  logic             free_we;
  link_t            head_link_cur;
  logic             idx_in_pool;
  logic [AW-1:0]    idx_addr;

  logic [CNT_W-1:0] build_src;
  logic [SW-1:0]    build_wide;
  logic [SW-1:0]    build_clamped;
  logic [CW-1:0]    build_n;
  logic [AW-1:0]    build_head;
  link_t            build_link;

  // Conditions watched by the assertions.
  logic             alloc_go;
  logic             free_go;
  logic             head_out;
  logic             sweep_out;

  // Handshakes: configuration is always taken; the input register frees when its request runs.
  assign cfg_ready = 1'b1;
  assign proc_go   = req_full_q && !sweeping_q && (!rsp_valid_q || rsp_ready);
  assign req_ready = !req_full_q || proc_go;

  // Pool size for a rebuild, clamped to one through the pool depth.
  assign build_src  = rst ? SLOT_COUNT_RESET : slot_count_q;
  assign build_wide = SW'(build_src);

  always_comb begin
    if (build_wide == '0) begin
      build_clamped = SW'(1);
    end else if (build_wide > SW'(POOL_DEPTH)) begin
      build_clamped = SW'(POOL_DEPTH);
    end else begin
      build_clamped = build_wide;
    end
  end

  assign build_n         = CW'(build_clamped);
  assign build_head      = AW'(build_n - CW'(1));
  assign build_link.valid = build_n > CW'(1);
  assign build_link.link  = AW'(build_n - CW'(2));

  // The head's own link comes from the memory right after an allocate, else from the register.
  assign head_link_cur = link_fresh_q ? link_t'(ram_rdata) : head_link_q;
  assign ram_raddr     = head_link_cur.link;

  assign idx_in_pool = FW'(idx_q) < FW'(live_count_q);
  assign idx_addr    = AW'(idx_q);

  // Command processing between the input register and the response register.
  always_comb begin
    live_count_next = live_count_q;
    head_next       = head_q;
    head_valid_next = head_valid_q;
    head_link_next  = head_link_cur;
    link_fresh_next = 1'b0;
    used_next       = used_q;
    id_next         = id_q;
    status_next     = ST_OK;
    granted_next    = '0;
    ticket_id_next  = '0;
    start_sweep     = 1'b0;
    free_we         = 1'b0;
    if (proc_go) begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (!head_valid_q) begin
            status_next = ST_EMPTY;
          end else begin
            granted_next    = IDX_W'(head_q);
            head_next       = head_link_cur.link;
            head_valid_next = head_link_cur.valid;
            link_fresh_next = 1'b1;
            if (used_q < USED_MAX) begin
              used_next = used_q + CNT_W'(1);
            end
          end
        end
        CMD_FREE: begin
          if (!idx_in_pool) begin
            status_next = ST_RANGE;
          end else begin
            free_we              = 1'b1;
            head_link_next.valid = head_valid_q;
            head_link_next.link  = head_q;
            head_next            = idx_addr;
            head_valid_next      = 1'b1;
            if (used_q != '0) begin
              used_next = used_q - CNT_W'(1);
            end
          end
        end
        CMD_NEXT_ID: begin
          ticket_id_next = id_q;
          id_next        = id_q + ID_W'(1);
        end
        CMD_INIT: begin
          live_count_next = build_n;
          head_next       = build_head;
          head_valid_next = 1'b1;
          head_link_next  = build_link;
          used_next       = '0;
          id_next         = ID_RESET;
          start_sweep     = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Link memory writes: the clearing pass, or the push of a freed slot.
  always_comb begin
    if (sweeping_q) begin
      ram_we          = 1'b1;
      ram_waddr       = sweep_idx_q;
      ram_wdata.valid = sweep_idx_q != '0;
      ram_wdata.link  = sweep_idx_q - AW'(1);
    end else begin
      ram_we          = free_we;
      ram_waddr       = idx_addr;
      ram_wdata.valid = head_valid_q;
      ram_wdata.link  = head_q;
    end
  end

  // Control and free list registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count_q <= SLOT_COUNT_RESET;
      req_full_q   <= 1'b0;
      rsp_valid_q  <= 1'b0;
      live_count_q <= build_n;
      head_q       <= build_head;
      head_valid_q <= 1'b1;
      head_link_q  <= build_link;
      link_fresh_q <= 1'b0;
      used_q       <= '0;
      id_q         <= ID_RESET;
      sweeping_q   <= 1'b1;
      sweep_idx_q  <= '0;
    end else begin
      if (cfg_valid) begin
        slot_count_q <= slot_count;
      end
      if (req_ready) begin
        req_full_q <= req_valid;
      end
      if (proc_go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid_q <= 1'b0;
      end
      live_count_q <= live_count_next;
      head_q       <= head_next;
      head_valid_q <= head_valid_next;
      head_link_q  <= head_link_next;
      link_fresh_q <= link_fresh_next;
      used_q       <= used_next;
      id_q         <= id_next;
      // Clearing pass over the slots of the rebuilt pool.
      if (start_sweep) begin
        sweeping_q  <= 1'b1;
        sweep_idx_q <= '0;
      end else if (sweeping_q) begin
        if (CW'(sweep_idx_q) == live_count_q - CW'(1)) begin
          sweeping_q <= 1'b0;
        end else begin
          sweep_idx_q <= sweep_idx_q + AW'(1);
        end
      end
    end
  end

  // Request and response payload registers.
  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      cmd_q <= cmd_t'(command);
      idx_q <= slot_index;
    end
    if (proc_go) begin
      status_q    <= status_next;
      granted_q   <= granted_next;
      rsp_used_q  <= used_next;
      ticket_id_q <= ticket_id_next;
    end
  end

  assign rsp_valid     = rsp_valid_q;
  assign status        = status_q;
  assign granted_index = granted_q;
  assign slots_in_use  = rsp_used_q;
  assign ticket_id     = ticket_id_q;

  sfl_ram #(
    .WIDTH ($bits(link_t)),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An emptied list leaves a stale head, so only a valid head is checked.
  assign alloc_go  = proc_go && (cmd_q == CMD_ALLOC);
  assign free_go   = proc_go && (cmd_q == CMD_FREE);
  assign head_out  = head_valid_q && !(CW'(head_q) < live_count_q);
  assign sweep_out = sweeping_q && !(CW'(sweep_idx_q) < live_count_q);

  // A valid head always names a slot of the live pool.
  `ASSERT_NEVER(a_head_in_pool, clk, rst, head_out, "head outside pool")
  // The clearing pass never runs past the live pool.
  `ASSERT_NEVER(a_sweep_in_pool, clk, rst, sweep_out, "sweep past pool")
  // The link memory is written only by the clearing pass or by a free.
  `ASSERT_CLK(a_write_source, clk, rst, ram_we |-> (sweeping_q || free_go), "stray link write")
  // A fresh memory link follows directly on an allocate.
  `ASSERT_CLK(a_fresh_after_alloc, clk, rst, link_fresh_q |-> $past(alloc_go), "stale link used")

endmodule

`default_nettype wire
